// ===== hw/rtl/rlv_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlv_pkg
// Types and constants shared by the run-length line validator modules.
// ----------------------------------------------------------------------------
package rlv_pkg;

    localparam int RUN_W  = 16;
    localparam int SUM_W  = 17;
    localparam int CODE_W = 3;
    localparam int PADDR_W = 3;

    localparam logic [RUN_W-1:0] ESCAPE_RUN = 16'd32767;
    localparam logic [SUM_W-1:0] SUM_MAX    = 17'h1FFFF;

    // Line walk phase codes
    localparam logic [1:0] PH_FIRST = 2'd0;
    localparam logic [1:0] PH_WALK  = 2'd1;
    localparam logic [1:0] PH_TRAIL = 2'd2;
    localparam logic [1:0] PH_DONE  = 2'd3;

    // Verdict codes
    localparam logic [CODE_W-1:0] ERR_NONE      = 3'd0;
    localparam logic [CODE_W-1:0] ERR_EVEN      = 3'd1;
    localparam logic [CODE_W-1:0] ERR_ZERO_RUN  = 3'd2;
    localparam logic [CODE_W-1:0] ERR_PIXELS    = 3'd3;
    localparam logic [CODE_W-1:0] ERR_TRAIL     = 3'd4;
    localparam logic [CODE_W-1:0] ERR_SIZE      = 3'd5;
    localparam logic [CODE_W-1:0] ERR_SHORT     = 3'd6;

    // Register index
    localparam logic REG_LINE_WIDTH = 1'b0;

    typedef struct packed {
        logic [RUN_W-1:0] run_length;
        logic             last_word;
    } rlv_word_t;

    typedef struct packed {
        logic              line_ok;
        logic [CODE_W-1:0] error_code;
    } rlv_verdict_t;

    typedef struct packed {
        logic [SUM_W-1:0]  pixel_sum;
        logic [RUN_W-1:0]  prev_run;
        logic [1:0]        phase;
        logic              walk_index_odd;
        logic              word_count_odd;
        logic [CODE_W-1:0] first_error;
    } rlv_state_t;

    localparam rlv_state_t STATE_CLEAR = '{
        pixel_sum:      '0,
        prev_run:       '0,
        phase:          PH_FIRST,
        walk_index_odd: 1'b0,
        word_count_odd: 1'b0,
        first_error:    ERR_NONE
    };

endpackage

// ===== hw/rtl/rlv_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlv_cfg
// APB register file holding the expected line width.
// ----------------------------------------------------------------------------
module rlv_cfg
    import rlv_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output logic [RUN_W-1:0]   line_width
);

    logic [RUN_W-1:0] line_width_reg;
    logic [RUN_W-1:0] line_width_next;
    logic             hit;

    // Register index is the address above the byte offset
    assign hit = (paddr[2] == REG_LINE_WIDTH);

    always_comb
    begin
        line_width_next = line_width_reg;
        if (psel && penable && pwrite && hit)
        begin
            line_width_next = pwdata[RUN_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_reg <= '0;
        end
        else
        begin
            line_width_reg <= line_width_next;
        end
    end

    assign prdata     = hit ? {16'd0, line_width_reg} : 32'd0;
    assign pready     = 1'b1;
    assign line_width = line_width_reg;

endmodule

// ===== hw/rtl/rlv_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlv_step
// Next-state and verdict logic for one run word of the line walk.
// ----------------------------------------------------------------------------
module rlv_step
    import rlv_pkg::*;
(
    input  rlv_state_t       cur,
    input  rlv_word_t        word,
    input  logic [RUN_W-1:0] width,
    output rlv_state_t       nxt,
    output logic             verdict_valid,
    output rlv_verdict_t     verdict
);

    logic [SUM_W:0]      sum_wide;
    logic [SUM_W-1:0]    sum_sat;
    logic [SUM_W-1:0]    width_ext;
    logic                run_zero;
    rlv_state_t          walk;
    logic [CODE_W-1:0]   rec_code;
    logic                do_check;
    logic                wio_new;
    logic [CODE_W-1:0]   code;

    assign sum_wide  = {1'b0, cur.pixel_sum} + {2'b00, word.run_length};
    assign sum_sat   = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
    assign width_ext = {1'b0, width};
    assign run_zero  = (word.run_length == '0);

    always_comb
    begin
        walk     = cur;
        rec_code = ERR_NONE;
        do_check = 1'b0;
        wio_new  = cur.walk_index_odd;

        unique case (cur.phase)
            PH_FIRST:
            begin
                walk.pixel_sum = sum_sat;
                wio_new        = 1'b1;
                do_check       = 1'b1;
            end
            PH_WALK:
            begin
                // a zero run is only legal right after an escape word
                if (run_zero && (cur.prev_run != ESCAPE_RUN))
                begin
                    rec_code = ERR_ZERO_RUN;
                end
                else
                begin
                    walk.pixel_sum = sum_sat;
                    wio_new        = ~cur.walk_index_odd;
                    do_check       = 1'b1;
                end
            end
            PH_TRAIL:
            begin
                if (!run_zero)
                begin
                    rec_code = ERR_TRAIL;
                end
                else
                begin
                    walk.phase = PH_DONE;
                end
            end
            PH_DONE:
            begin
                rec_code = ERR_SIZE;
            end
        endcase

        walk.walk_index_odd = wio_new;

        if (do_check)
        begin
            priority if (sum_sat < width_ext)
            begin
                walk.phase = PH_WALK;
            end
            else if (sum_sat != width_ext)
            begin
                rec_code = ERR_PIXELS;
            end
            else
            begin
                walk.phase = wio_new ? PH_DONE : PH_TRAIL;
            end
        end

        // keep the first error only, and close the walk
        if (rec_code != ERR_NONE)
        begin
            if (cur.first_error == ERR_NONE)
            begin
                walk.first_error = rec_code;
            end
            walk.phase = PH_DONE;
        end

        walk.prev_run       = word.run_length;
        walk.word_count_odd = ~cur.word_count_odd;

        priority if (!walk.word_count_odd)
        begin
            code = ERR_EVEN;
        end
        else if (walk.first_error != ERR_NONE)
        begin
            code = walk.first_error;
        end
        else if (walk.phase == PH_DONE)
        begin
            code = ERR_NONE;
        end
        else if (walk.phase == PH_TRAIL)
        begin
            code = ERR_SIZE;
        end
        else
        begin
            code = ERR_SHORT;
        end

        verdict_valid      = word.last_word;
        verdict.line_ok    = (code == ERR_NONE);
        verdict.error_code = code;
        nxt                = word.last_word ? STATE_CLEAR : walk;
    end

endmodule

// ===== hw/rtl/rle_line_validator_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rle_line_validator_top
// Validates one run-length coded bilevel line and reports one verdict per line.
// ----------------------------------------------------------------------------
// Run words enter on the word channel, one transfer per clock at full rate;
// each word is captured in an input register, walked through a single short
// step (one 17-bit saturating add, one compare against the line width, and a
// phase update), and the verdict for a word marked last is registered into the
// result register when the step processes it. Throughput is one word per cycle,
// limited only by the verdict channel: the input register can still take one word
// while a finished verdict waits, and stall backs up only when both the input
// register and the result register are occupied and the verdict is stalled.
// Words that are not marked last produce no verdict. The line width is
// programmed over APB at byte address 0 and is clamped to MAX_LINE_WIDTH;
// write it only while no line is in flight. Verdict codes: 0 ok, 1 even word
// count, 2 inward zero run, 3 pixel count mismatch, 4 trailing run nonzero,
// 5 size mismatch, 6 line too short; line_ok is high exactly for code 0.
// ----------------------------------------------------------------------------
module rle_line_validator_top
    import rlv_pkg::*;
#(
    parameter int MAX_LINE_WIDTH = 65535
)
(
    input  logic               clk,
    input  logic               rst_n,
    // run word channel
    input  logic               word_valid,
    output logic               word_stall,
    input  rlv_word_t          word,
    // verdict channel
    output logic               verdict_valid,
    input  logic               verdict_stall,
    output rlv_verdict_t       verdict,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam logic [RUN_W-1:0] MAX_WIDTH = RUN_W'(MAX_LINE_WIDTH);

    logic [RUN_W-1:0] line_width;
    logic [RUN_W-1:0] width_eff;

    // input register
    logic             in_valid_reg;
    logic             in_valid_next;
    rlv_word_t        in_word_reg;

    // line walk state
    rlv_state_t       state_reg;
    rlv_state_t       state_next;
    rlv_state_t       step_state;

    // result register
    logic             out_valid_reg;
    logic             out_valid_next;
    rlv_verdict_t     out_verdict_reg;

    logic             step_valid;
    rlv_verdict_t     step_verdict;
    logic             advance;
    logic             process;
    logic             word_xfer;

    rlv_cfg u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .line_width (line_width)
    );

    // clamp the programmed width to the supported maximum
    assign width_eff = (line_width > MAX_WIDTH) ? MAX_WIDTH : line_width;

    rlv_step u_step (
        .cur           (state_reg),
        .word          (in_word_reg),
        .width         (width_eff),
        .nxt           (step_state),
        .verdict_valid (step_valid),
        .verdict       (step_verdict)
    );

    // The result register can take a new verdict when empty or being drained.
    assign advance    = !out_valid_reg || !verdict_stall;
    // Consume the buffered word whenever the result side can move.
    assign process    = in_valid_reg && advance;
    // Stall the word channel only when the buffered word cannot move on.
    assign word_stall = in_valid_reg && !advance;
    assign word_xfer  = word_valid && !word_stall;

    always_comb
    begin
        in_valid_next  = word_xfer || (in_valid_reg && !advance);
        state_next     = process ? step_state : state_reg;
        out_valid_next = process ? step_valid : (out_valid_reg && verdict_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= STATE_CLEAR;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            state_reg     <= state_next;
        end
    end

    // payload registers: load on transfer, hold otherwise
    always_ff @(posedge clk)
    begin
        if (word_xfer)
        begin
            in_word_reg <= word;
        end
        if (process && step_valid)
        begin
            out_verdict_reg <= step_verdict;
        end
    end

    assign verdict_valid = out_valid_reg;
    assign verdict       = out_verdict_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------

    // line_ok must agree with the code in every delivered verdict
    a_ok_matches_code: assert property (@(posedge clk) disable iff (!rst_n)
        verdict_valid |-> (verdict.line_ok == (verdict.error_code == ERR_NONE)))
        else $error("line_ok disagrees with error_code");

    // a word marked last leaves the walk state cleared
    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (process && in_word_reg.last_word) |=>
            (state_reg.phase == PH_FIRST && state_reg.pixel_sum == '0
             && state_reg.first_error == ERR_NONE && !state_reg.word_count_odd))
        else $error("walk state not cleared after line end");

    // a processed last word must show up as a verdict in the next cycle
    a_verdict_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (process && in_word_reg.last_word) |=> verdict_valid)
        else $error("verdict missing after last word");

    // stall is raised only with a word held that cannot advance
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        word_stall |-> (in_valid_reg && verdict_valid && verdict_stall))
        else $error("word channel stalled without cause");

endmodule

// ===== tb/sv/rlv_tb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlv_tb_pkg
// Verdict scoreboard for the run-length line validator test: tracks the line
// walk word by word and holds the verdicts still owed by the block.
// ----------------------------------------------------------------------------
package rlv_tb_pkg;

    import rlv_pkg::*;

    class line_verdict_board;

        rlv_state_t       walk;
        logic [RUN_W-1:0] width;
        rlv_verdict_t     verdicts_due[$];
        int unsigned      mismatches;

        function new();
            walk = STATE_CLEAR;
            width = '0;
            mismatches = 0;
        endfunction

        function void set_width(input logic [RUN_W-1:0] w);
            width = w;
        endfunction

        function int unsigned pending();
            return verdicts_due.size();
        endfunction

        // Saturating pixel sum.
        function void add_run(input logic [RUN_W-1:0] run);
            logic [SUM_W:0] total;
            total = {1'b0, walk.pixel_sum} + {2'b00, run};
            walk.pixel_sum = (total > {1'b0, SUM_MAX}) ? SUM_MAX : total[SUM_W-1:0];
        endfunction

        // Keep the first error only; any error ends the walk.
        function void flag_error(input logic [CODE_W-1:0] code);
            if (walk.first_error == ERR_NONE)
                walk.first_error = code;
            walk.phase = PH_DONE;
        endfunction

        function void close_if_reached();
            if (walk.pixel_sum < {1'b0, width})
                walk.phase = PH_WALK;
            else if (walk.pixel_sum != {1'b0, width})
                flag_error(ERR_PIXELS);
            else
                walk.phase = walk.walk_index_odd ? PH_DONE : PH_TRAIL;
        endfunction

        function void note_word(input rlv_word_t w);
            rlv_verdict_t      v;
            logic [CODE_W-1:0] code;
            case (walk.phase)
                PH_FIRST:
                begin
                    add_run(w.run_length);
                    walk.walk_index_odd = 1'b1;
                    close_if_reached();
                end
                PH_WALK:
                begin
                    if (w.run_length == '0 && walk.prev_run != ESCAPE_RUN)
                        flag_error(ERR_ZERO_RUN);
                    else
                    begin
                        add_run(w.run_length);
                        walk.walk_index_odd = ~walk.walk_index_odd;
                        close_if_reached();
                    end
                end
                PH_TRAIL:
                begin
                    if (w.run_length != '0)
                        flag_error(ERR_TRAIL);
                    else
                        walk.phase = PH_DONE;
                end
                default:
                    flag_error(ERR_SIZE);
            endcase
            walk.prev_run = w.run_length;
            walk.word_count_odd = ~walk.word_count_odd;
            if (!w.last_word)
                return;
            if (!walk.word_count_odd)
                code = ERR_EVEN;
            else if (walk.first_error != ERR_NONE)
                code = walk.first_error;
            else if (walk.phase == PH_DONE)
                code = ERR_NONE;
            else if (walk.phase == PH_TRAIL)
                code = ERR_SIZE;
            else
                code = ERR_SHORT;
            v.line_ok = (code == ERR_NONE);
            v.error_code = code;
            verdicts_due.push_back(v);
            walk = STATE_CLEAR;
        endfunction

        function void report(input string field, input int want, input int got);
            mismatches++;
            if (mismatches <= 50)
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        endfunction

        function void check_verdict(input rlv_verdict_t got);
            rlv_verdict_t want;
            if (verdicts_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 50)
                    $display("%0t: verdict mismatch, expected none, actual ok=%0b code=%0d",
                             $time, got.line_ok, got.error_code);
                return;
            end
            want = verdicts_due.pop_front();
            if (got.line_ok !== want.line_ok)
                report("line_ok", want.line_ok, got.line_ok);
            if (got.error_code !== want.error_code)
                report("error_code", want.error_code, got.error_code);
        endfunction

    endclass

endpackage

// ===== tb/sv/rle_line_validator_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rle_line_validator_top_test
// Streams run-length coded lines into the validator under several line
// widths, with random idle and stall on both channels, and compares every
// verdict against a cycle-free prediction of the line walk.
// ----------------------------------------------------------------------------
module rle_line_validator_top_test;

    import rlv_pkg::*;
    import rlv_tb_pkg::*;

    localparam int IDLE_PCT       = 38;
    localparam int RANDOM_WORDS   = 1500;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 5000;

    typedef logic [RUN_W-1:0] run_q_t[$];

    logic               clk;
    logic               rst_n = 1'b0;
    logic               word_valid = 1'b0;
    logic               word_stall;
    rlv_word_t          word = '0;
    logic               verdict_valid;
    logic               verdict_stall = 1'b0;
    rlv_verdict_t       verdict;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    line_verdict_board board = new();

    // steady: no idling on either side while set
    bit          steady = 1'b0;
    int unsigned quiet_cycles = 0;
    int unsigned words_sent = 0;

    rle_line_validator_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .word_valid    (word_valid),
        .word_stall    (word_stall),
        .word          (word),
        .verdict_valid (verdict_valid),
        .verdict_stall (verdict_stall),
        .verdict       (verdict),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Verdict side: check each transfer, then draw the stall for the next cycle.
    always @(posedge clk)
    begin
        if (rst_n && verdict_valid && !verdict_stall)
            board.check_verdict(verdict);
        verdict_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
    end

    // Count cycles in which no transfer of any kind happens.
    always @(posedge clk)
    begin
        if ((word_valid && !word_stall) || (verdict_valid && !verdict_stall) ||
            (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Watchdog: give up once the block has been silent for too long.
    initial
    begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    // Write the line width over APB: setup cycle, then access cycle.
    task automatic set_line_width(input logic [RUN_W-1:0] w);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(4 * int'(REG_LINE_WIDTH));
        pwdata  <= 32'(w);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        board.set_width(w);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Offer one word, with a random run of idle cycles in front of it, and
    // hold it until the transfer. Valid stays high into the next word when
    // no idle follows, so it never drops and rises in the same step.
    task automatic send_word(input logic [RUN_W-1:0] run, input logic last);
        int unsigned gap;
        gap = 0;
        if (!steady)
            while ($urandom_range(99) < IDLE_PCT)
                gap++;
        if (gap != 0)
        begin
            word_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        word_valid <= 1'b1;
        word       <= '{run_length: run, last_word: last};
        do
            @(posedge clk);
        while (word_stall);
        board.note_word(word);
        words_sent++;
    endtask

    // Send a whole line; the final word carries the last-word mark.
    task automatic send_line(input run_q_t runs);
        foreach (runs[i])
            send_word(runs[i], i == runs.size() - 1);
    endtask

    // Hold the sender until every owed verdict has arrived, then let any
    // words still inside the block drain out.
    task automatic settle();
        word_valid <= 1'b0;
        do
            @(posedge clk);
        while (board.pending() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Build a well-formed line for the given width, and spoil about a third
    // of them so every verdict code keeps turning up.
    function automatic run_q_t draw_line(input logic [RUN_W-1:0] width);
        run_q_t      runs;
        int unsigned left;
        int unsigned piece;
        int unsigned idx;
        int unsigned n;
        left = width;
        // zero width needs a single zero word; otherwise open with a zero run now and then
        if (width == '0 || $urandom_range(15) == 0)
            runs.push_back('0);
        while (left != 0)
        begin
            if (left > ESCAPE_RUN && $urandom_range(3) == 0)
            begin
                // escape word, then the zero run it allows
                runs.push_back(ESCAPE_RUN);
                runs.push_back('0);
                left -= ESCAPE_RUN;
            end
            else
            begin
                piece = ($urandom_range(3) == 0) ? left : $urandom_range(left, 1);
                runs.push_back(RUN_W'(piece));
                left -= piece;
            end
        end
        // walk covers an even number of words: append the trailing zero run
        if (runs.size() % 2 == 0)
            runs.push_back('0);
        if ($urandom_range(9) < 3)
        begin
            idx = $urandom_range(runs.size() - 1);
            case ($urandom_range(5))
                0:
                    // inward zero run
                    if (runs.size() > 1)
                        runs[$urandom_range(runs.size() - 1, 1)] = '0;
                1:
                    // cut the line short, or drop its trailing zero
                    if (runs.size() > 1)
                        void'(runs.pop_back());
                2:
                    // extra word after the line is complete
                    runs.push_back(($urandom_range(1) == 0) ? '0 : RUN_W'($urandom));
                3:
                    // pixel count off by one
                    runs[idx] = ($urandom_range(1) == 0) ? runs[idx] + 1'b1 : runs[idx] - 1'b1;
                4:
                    // nonzero final word
                    runs[runs.size() - 1] = RUN_W'($urandom_range(65535, 1));
                default:
                begin
                    // noise: short burst of arbitrary words
                    runs = {};
                    n = $urandom_range(6, 1);
                    repeat (n)
                        runs.push_back(($urandom_range(1) == 0) ? RUN_W'($urandom_range(15))
                                                                : RUN_W'($urandom));
                end
            endcase
        end
        return runs;
    endfunction

    initial
    begin
        logic [RUN_W-1:0] width;
        int unsigned      stage;
        int unsigned      lines;
        int unsigned      start_count;

        // Hold reset, then release it once for the whole run.
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed lines at a small width: clean lines with and without the
        // trailing zero, then each walk error and both ways a line can end
        // badly (missing trailing zero, short line).
        set_line_width(16'd10);
        send_line('{16'd10});
        send_line('{16'd4, 16'd6, 16'd0});
        send_line('{16'd4, 16'd6});
        send_line('{16'd4, 16'd0, 16'd6});
        send_line('{16'd4, 16'd7, 16'd0});
        send_line('{16'd4, 16'd6, 16'd5});
        send_line('{16'd10, 16'd1, 16'd2});
        send_line('{16'd3});
        settle();

        // Zero width: the first word alone must match.
        set_line_width('0);
        send_line('{16'd0});
        send_line('{16'd5});
        settle();

        // Full width reached through an escape word and its zero run.
        set_line_width(16'hFFFF);
        send_line('{ESCAPE_RUN, 16'd0, 16'd32768});
        settle();

        // Random lines, one width per stage; open with the extremes.
        stage = 0;
        start_count = words_sent;
        while (words_sent - start_count < RANDOM_WORDS)
        begin
            case (stage)
                0:       width = 16'hFFFF;
                1:       width = '0;
                2:       width = 16'd1;
                default:
                    case ($urandom_range(9))
                        0:       width = 16'hFFFF;
                        1:       width = '0;
                        2, 3, 4, 5: width = RUN_W'($urandom_range(64, 1));
                        6, 7:    width = RUN_W'($urandom_range(1023, 65));
                        default: width = RUN_W'($urandom);
                    endcase
            endcase
            // one long stage runs with no idling on either side
            steady = (stage == 4);
            lines = steady ? 60 : $urandom_range(40, 15);
            set_line_width(width);
            repeat (lines)
            begin
                send_line(draw_line(width));
                // now and then drain the block completely mid-stage
                if ($urandom_range(39) == 0)
                    settle();
            end
            settle();
            steady = 1'b0;
            stage++;
        end

        if (board.mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
